@@ design/assert_macros.svh @@
// assertion macros shared by the voicer rtl
// expects clk_i and rst_ni in the scope of each use
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// plain clocked property, off while in reset
`define CIV_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// same-cycle implication
`define CIV_ASSERT_IMP(lbl, ante, cons, msg) \
  `CIV_ASSERT(lbl, (ante) |-> (cons), msg)

// next-cycle implication
`define CIV_ASSERT_NXT(lbl, ante, cons, msg) \
  `CIV_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

@@ design/civ_pkg.sv @@
// shared types, constants and helpers for the chord inversion voicer
// no dependencies
package civ_pkg;

  localparam int unsigned NUM_PARTIALS_DEF = 8;
  localparam int unsigned MAX_PARTIALS     = 8;
  localparam int unsigned SEL_W            = $clog2(MAX_PARTIALS);
  localparam int unsigned CNT_W            = $clog2(MAX_PARTIALS + 1);

  localparam int unsigned IDX_W     = 4;
  localparam int unsigned ENTRY_W   = 8;
  localparam int unsigned OUT_W     = 9;
  localparam int unsigned TABLE_W   = 64;
  localparam int unsigned MASK_W    = 8;
  localparam int unsigned INV_W     = 6;
  localparam int unsigned SPREAD_W  = 8;
  localparam int unsigned CFG_IDX_W = 4;
  localparam int unsigned LIFT_W    = 6;

  // multiple of every chord size 1..8, keeps the inversion sum positive
  localparam int unsigned MOD_OFFSET = 840;
  localparam int unsigned MOD_W      = 10;

  localparam logic [TABLE_W-1:0]  TABLE_RST  = 64'd768;
  localparam logic [MASK_W-1:0]   MASK_RST   = 8'd3;
  localparam logic [INV_W-1:0]    INV_RST    = '0;
  localparam logic [SPREAD_W-1:0] SPREAD_RST = '0;

  typedef logic [CNT_W-1:0] cnt_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_INTERVAL_TABLE = 4'd0,
    CFG_ACTIVE_MASK    = 4'd1,
    CFG_INVERSION      = 4'd2,
    CFG_VOICE_SPREAD   = 4'd3
  } cfg_reg_e;

  // chord summary handed from the ordering logic to the pipeline
  typedef struct packed {
    logic [MAX_PARTIALS-1:0] act;
    cnt_t                    n;
  } chord_t;

  function automatic logic signed [ENTRY_W-1:0] entry_of(
    input logic [TABLE_W-1:0] tbl,
    input logic [SEL_W-1:0]   k
  );
    return tbl[{k, 3'b000} +: ENTRY_W];
  endfunction

  // 12 * ceil(s / 64), one more octave above 160
  function automatic logic [LIFT_W-1:0] spread_lift(input logic [SPREAD_W-1:0] s);
    logic [LIFT_W-1:0] l;
    case (s) inside
      [8'd1:8'd64]:    l = 6'd12;
      [8'd65:8'd128]:  l = 6'd24;
      [8'd129:8'd160]: l = 6'd36;
      [8'd161:8'd192]: l = 6'd48;
      [8'd193:8'd255]: l = 6'd60;
      default:         l = 6'd0;
    endcase
    return l;
  endfunction

endpackage

@@ design/civ_order.sv @@
// sorted-position bounds of every active interval, from the config registers
// depends on civ_pkg
module civ_order import civ_pkg::*; #(
  parameter int unsigned NUM_PARTIALS = NUM_PARTIALS_DEF
) (
  input  logic [TABLE_W-1:0] interval_table_i,
  input  logic [MASK_W-1:0]  active_mask_i,
  output chord_t             chord_o,
  output cnt_t               lt_cnt_o [MAX_PARTIALS],
  output cnt_t               le_cnt_o [MAX_PARTIALS]
);

  logic [MAX_PARTIALS-1:0] act;
  cnt_t                    n;

  always_comb begin
    n = '0;
    for (int k = 0; k < MAX_PARTIALS; k++) begin
      act[k] = active_mask_i[k] && (k < NUM_PARTIALS);
      n      = n + CNT_W'(act[k]);
    end
  end

  // entry k covers sorted positions lt..le-1
  always_comb begin
    for (int k = 0; k < MAX_PARTIALS; k++) begin
      lt_cnt_o[k] = '0;
      le_cnt_o[k] = '0;
      for (int j = 0; j < MAX_PARTIALS; j++) begin
        lt_cnt_o[k] = lt_cnt_o[k] + CNT_W'(act[j] &&
          (entry_of(interval_table_i, SEL_W'(j)) < entry_of(interval_table_i, SEL_W'(k))));
        le_cnt_o[k] = le_cnt_o[k] + CNT_W'(act[j] &&
          (entry_of(interval_table_i, SEL_W'(j)) <= entry_of(interval_table_i, SEL_W'(k))));
      end
    end
  end

  assign chord_o.act = act;
  assign chord_o.n   = n;

endmodule

@@ design/chord_inversion_voicer.sv @@
// chord inversion voicer top level: config registers and four-stage query pipeline
// depends on civ_pkg, civ_order and assert_macros.svh
//
//   channel  | dir | handshake                  | word
//   ---------+-----+----------------------------+------------------------------
//   in       | in  | in_valid_i / in_ready_o    | partial_index_i
//   out      | out | out_valid_o / out_ready_i  | voiced_interval_o
//   cfg      | in  | cfg_valid_i / cfg_ready_o  | cfg_index_i, cfg_data_i
//
// one index a cycle while the output is not stalled, result registered through stages a, b, c and d
// stages: index decode, rank count, inversion modulo and rotate, select and lift
// reset clears the stage valids and loads the register reset values
// a stalled output backs up stage by stage, a stage takes a word when it empties
`include "assert_macros.svh"
module chord_inversion_voicer import civ_pkg::*; #(
  parameter int unsigned NUM_PARTIALS = NUM_PARTIALS_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    cfg_valid_i,
  output logic                    cfg_ready_o,
  input  logic [CFG_IDX_W-1:0]    cfg_index_i,
  input  logic [TABLE_W-1:0]      cfg_data_i,
  input  logic                    in_valid_i,
  output logic                    in_ready_o,
  input  logic [IDX_W-1:0]        partial_index_i,
  output logic                    out_valid_o,
  input  logic                    out_ready_i,
  output logic signed [OUT_W-1:0] voiced_interval_o
);

  logic [TABLE_W-1:0]  table_q;
  logic [MASK_W-1:0]   mask_q;
  logic [INV_W-1:0]    inv_q;
  logic [SPREAD_W-1:0] spread_q;

  chord_t chord;
  cnt_t   lt_cnt [MAX_PARTIALS];
  cnt_t   le_cnt [MAX_PARTIALS];

  logic va_q, vb_q, vc_q, vd_q;
  logic ra, rb, rc, rd;

  logic                      a_inr_q, b_inr_q, c_inr_q;
  logic signed [ENTRY_W-1:0] a_base_q, b_base_q, c_base_q;
  logic [MOD_W-1:0]          a_x_q, b_x_q;
  cnt_t                      b_rank_q, c_rot_q;
  logic signed [OUT_W-1:0]   d_val_q;

  logic                      a_inr_d;
  logic signed [ENTRY_W-1:0] a_base_d;
  logic [MOD_W-1:0]          a_x_d, b_x_d, c_x;
  cnt_t                      b_rank_d, c_rot_d;
  logic [CNT_W:0]            c_sum;
  logic signed [ENTRY_W-1:0] d_sel;
  logic [LIFT_W-1:0]         d_lift;
  logic signed [OUT_W-1:0]   d_val_d;

  // one restoring step: subtract n << k when it fits
  function automatic logic [MOD_W-1:0] mod_step(
    input logic [MOD_W-1:0] x,
    input cnt_t             n,
    input int unsigned      k
  );
    logic [MOD_W+CNT_W-1:0] d;
    logic [MOD_W-1:0]       r;
    d = (MOD_W + CNT_W)'(n) << k;
    r = x;
    if ((MOD_W + CNT_W)'(x) >= d) begin
      r = x - MOD_W'(d);
    end
    return r;
  endfunction

  // ---------------- config registers ----------------
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      table_q  <= TABLE_RST;
      mask_q   <= MASK_RST;
      inv_q    <= INV_RST;
      spread_q <= SPREAD_RST;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_INTERVAL_TABLE: table_q  <= cfg_data_i;
        CFG_ACTIVE_MASK:    mask_q   <= cfg_data_i[MASK_W-1:0];
        CFG_INVERSION:      inv_q    <= cfg_data_i[INV_W-1:0];
        CFG_VOICE_SPREAD:   spread_q <= cfg_data_i[SPREAD_W-1:0];
        default: ;
      endcase
    end
  end

  civ_order #(
    .NUM_PARTIALS(NUM_PARTIALS)
  ) u_order (
    .interval_table_i(table_q),
    .active_mask_i   (mask_q),
    .chord_o         (chord),
    .lt_cnt_o        (lt_cnt),
    .le_cnt_o        (le_cnt)
  );

  // ---------------- flow control ----------------
  assign rd         = !vd_q || out_ready_i;
  assign rc         = !vc_q || rd;
  assign rb         = !vb_q || rc;
  assign ra         = !va_q || rb;
  assign in_ready_o = ra;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      va_q <= 1'b0;
      vb_q <= 1'b0;
      vc_q <= 1'b0;
      vd_q <= 1'b0;
    end else begin
      if (ra) va_q <= in_valid_i;
      if (rb) vb_q <= va_q;
      if (rc) vc_q <= vb_q;
      if (rd) vd_q <= vc_q;
    end
  end

  // ---------------- stage a: decode index ----------------
  always_comb begin
    a_inr_d  = partial_index_i < IDX_W'(NUM_PARTIALS);
    a_base_d = entry_of(table_q, partial_index_i[SEL_W-1:0]);
    // inversion plus offset, then the top quotient bits
    a_x_d = MOD_W'(MOD_OFFSET) + {{(MOD_W - INV_W){inv_q[INV_W-1]}}, inv_q};
    a_x_d = mod_step(a_x_d, chord.n, 9);
    a_x_d = mod_step(a_x_d, chord.n, 8);
    a_x_d = mod_step(a_x_d, chord.n, 7);
  end

  // ---------------- stage b: rank of the queried interval ----------------
  always_comb begin
    b_rank_d = '0;
    for (int k = 0; k < MAX_PARTIALS; k++) begin
      b_rank_d = b_rank_d + CNT_W'(chord.act[k] &&
        (entry_of(table_q, SEL_W'(k)) < a_base_q));
    end
    b_x_d = mod_step(a_x_q, chord.n, 6);
    b_x_d = mod_step(b_x_d, chord.n, 5);
    b_x_d = mod_step(b_x_d, chord.n, 4);
    b_x_d = mod_step(b_x_d, chord.n, 3);
  end

  // ---------------- stage c: finish modulo, rotate rank ----------------
  always_comb begin
    c_x = mod_step(b_x_q, chord.n, 2);
    c_x = mod_step(c_x, chord.n, 1);
    c_x = mod_step(c_x, chord.n, 0);
    // rank <= n and inversion < n, so one subtract wraps
    c_sum = (CNT_W + 1)'(b_rank_q) + (CNT_W + 1)'(c_x[CNT_W-1:0]);
    if (c_sum >= (CNT_W + 1)'(chord.n)) begin
      c_sum = c_sum - (CNT_W + 1)'(chord.n);
    end
    c_rot_d = c_sum[CNT_W-1:0];
  end

  // ---------------- stage d: pick sorted entry, apply spread ----------------
  always_comb begin
    d_sel = '0;
    for (int k = 0; k < MAX_PARTIALS; k++) begin
      if (chord.act[k] && (lt_cnt[k] <= c_rot_q) && (c_rot_q < le_cnt[k])) begin
        d_sel = entry_of(table_q, SEL_W'(k));
      end
    end
    d_lift = (c_rot_q >= (chord.n >> 1)) ? spread_lift(spread_q) : '0;
    if (!c_inr_q) begin
      d_val_d = '0;
    end else if (chord.n == '0) begin
      d_val_d = OUT_W'(c_base_q);
    end else begin
      d_val_d = OUT_W'(d_sel) + $signed(OUT_W'(d_lift));
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (ra && in_valid_i) begin
      a_inr_q  <= a_inr_d;
      a_base_q <= a_base_d;
      a_x_q    <= a_x_d;
    end
    if (rb && va_q) begin
      b_inr_q  <= a_inr_q;
      b_base_q <= a_base_q;
      b_x_q    <= b_x_d;
      b_rank_q <= b_rank_d;
    end
    if (rc && vb_q) begin
      c_inr_q  <= b_inr_q;
      c_base_q <= b_base_q;
      c_rot_q  <= c_rot_d;
    end
    if (rd && vc_q) begin
      d_val_q <= d_val_d;
    end
  end

  assign out_valid_o       = vd_q;
  assign voiced_interval_o = d_val_q;

  // ---------------- assertions ----------------
  `CIV_ASSERT_NXT(a_accept_lands, in_valid_i && in_ready_o, va_q,
    "accepted word did not enter stage a")
  `CIV_ASSERT_IMP(a_ready_full, !in_ready_o, va_q && vb_q && vc_q && vd_q && !out_ready_i,
    "input blocked with room in the pipeline")
  `CIV_ASSERT_IMP(a_rot_bound, vc_q && (chord.n != '0), c_rot_q < chord.n,
    "rotated rank outside the chord")
  `CIV_ASSERT_NXT(a_stall_holds, vb_q && !rb, vb_q,
    "stalled stage b word dropped")

endmodule

@@ dv/testbench.sv @@
// self-checking bench for chord_inversion_voicer: directed and random index queries
// over a range of chord settings, with results predicted in-bench
// depends on civ_pkg and the voicer rtl
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import civ_pkg::*;

  localparam int unsigned NPART       = NUM_PARTIALS_DEF;
  localparam int          DRAIN_CYC   = 12;
  localparam int          CYCLE_LIMIT = 200000;
  localparam int          RAND_PHASES = 12;
  localparam int          RAND_ITEMS  = 75;
  // register indexes from here up select no register
  localparam int          CFG_FIRST_UNUSED = 4;

  logic                    clk             = 1'b0;
  logic                    rst_n           = 1'b0;
  logic                    cfg_valid       = 1'b0;
  logic                    cfg_ready;
  logic [CFG_IDX_W-1:0]    cfg_index       = '0;
  logic [TABLE_W-1:0]      cfg_data        = '0;
  logic                    in_valid        = 1'b0;
  logic                    in_ready;
  logic [IDX_W-1:0]        partial_index   = '0;
  logic                    out_valid;
  logic                    out_ready       = 1'b0;
  logic signed [OUT_W-1:0] voiced_interval;

  // bench copy of the chord registers
  logic [TABLE_W-1:0]  tbl_m    = TABLE_RST;
  logic [MASK_W-1:0]   mask_m   = MASK_RST;
  logic [INV_W-1:0]    inv_m    = INV_RST;
  logic [SPREAD_W-1:0] spread_m = SPREAD_RST;

  logic [IDX_W-1:0]        index_q[$];
  logic signed [OUT_W-1:0] voice_q[$];
  int queued_n   = 0;
  int accepted_n = 0;
  int mismatches = 0;
  int gap_left   = 0;
  int stall_left = 0;
  int cycles     = 0;
  bit idle_on    = 1'b1;

  chord_inversion_voicer #(
    .NUM_PARTIALS(NPART)
  ) i_dut (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .cfg_valid_i      (cfg_valid),
    .cfg_ready_o      (cfg_ready),
    .cfg_index_i      (cfg_index),
    .cfg_data_i       (cfg_data),
    .in_valid_i       (in_valid),
    .in_ready_o       (in_ready),
    .partial_index_i  (partial_index),
    .out_valid_o      (out_valid),
    .out_ready_i      (out_ready),
    .voiced_interval_o(voiced_interval)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  function automatic logic signed [OUT_W-1:0] voice_of(input logic [IDX_W-1:0] pidx);
    int chord[MAX_PARTIALS];
    int n;
    int p;
    int v;
    int base;
    int rot;
    int rank;
    int res;
    logic signed [ENTRY_W-1:0] e;
    n = 0;
    if (pidx >= NPART) return '0;
    // insertion sort of the active intervals
    for (int k = 0; k < NPART; k++) begin
      if (mask_m[k]) begin
        e = tbl_m[8*k +: ENTRY_W];
        v = e;
        p = n;
        while (p > 0 && chord[p-1] > v) begin
          chord[p] = chord[p-1];
          p--;
        end
        chord[p] = v;
        n++;
      end
    end
    e = tbl_m[8*int'(pidx) +: ENTRY_W];
    base = e;
    if (n == 0) begin
      res = base;
    end else begin
      rot = int'($signed(inv_m));
      rot = ((rot % n) + n) % n;
      rank = 0;
      for (int k = 0; k < n; k++)
        if (chord[k] < base) rank++;
      rank = (rank + rot) % n;
      res = chord[rank];
      if (spread_m != 0 && rank >= n / 2) begin
        res += 12 * ((int'(spread_m) + 63) / 64);
        if (spread_m > 160) res += 12;
      end
    end
    return res[OUT_W-1:0];
  endfunction

  // query driver
  always @(posedge clk) begin : drive_p
    logic busy;
    if (rst_n) begin
      busy = in_valid;
      if (in_valid && in_ready) begin
        voice_q.push_back(voice_of(partial_index));
        accepted_n++;
        busy = 1'b0;
      end
      if (!busy) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (idle_on && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(0, 4);
          in_valid <= 1'b0;
        end else if (index_q.size() != 0) begin
          partial_index <= index_q.pop_front();
          in_valid <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // result monitor
  always @(posedge clk) begin : watch_p
    logic signed [OUT_W-1:0] want;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (voice_q.size() == 0) begin
          $display("%0t: voiced_interval expected none, got %0d", $time, voiced_interval);
          mismatches++;
        end else begin
          want = voice_q.pop_front();
          if (voiced_interval !== want) begin
            $display("%0t: voiced_interval expected %0d, got %0d", $time, want,
                     voiced_interval);
            mismatches++;
          end
        end
      end
      if (stall_left > 0) stall_left--;
      else if (idle_on && $urandom_range(0, 7) == 0) stall_left = $urandom_range(1, 5);
      out_ready <= (stall_left == 0);
    end
  end

  task automatic set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [TABLE_W-1:0] d);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      CFG_INTERVAL_TABLE: tbl_m    = d;
      CFG_ACTIVE_MASK:    mask_m   = d[MASK_W-1:0];
      CFG_INVERSION:      inv_m    = d[INV_W-1:0];
      CFG_VOICE_SPREAD:   spread_m = d[SPREAD_W-1:0];
      default: ;
    endcase
  endtask

  task automatic set_chord(input logic [TABLE_W-1:0] tbl, input logic [MASK_W-1:0] mask,
                           input logic [INV_W-1:0] inv, input logic [SPREAD_W-1:0] spread);
    logic [TABLE_W-1:0] junk;
    // unused upper data bits must be dropped by the narrow registers
    junk = $urandom_range(0, 1) ? {$urandom, $urandom} : '0;
    set_reg(CFG_INTERVAL_TABLE, tbl);
    set_reg(CFG_ACTIVE_MASK, {junk[TABLE_W-1:MASK_W], mask});
    set_reg(CFG_INVERSION, {junk[TABLE_W-1:INV_W], inv});
    set_reg(CFG_VOICE_SPREAD, {junk[TABLE_W-1:SPREAD_W], spread});
  endtask

  task automatic send(input logic [IDX_W-1:0] idx);
    index_q.push_back(idx);
    queued_n++;
  endtask

  // wait until every query is answered, then let the pipeline settle
  task automatic drain();
    while (accepted_n != queued_n || voice_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYC) @(posedge clk);
  endtask

  function automatic logic [ENTRY_W-1:0] pick_entry();
    case ($urandom_range(0, 5))
      0:       return 8'h80;
      1:       return 8'h7F;
      2, 3:    return 8'($urandom_range(0, 4)) + 8'hFE;  // small values, many ties
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [MASK_W-1:0] pick_mask();
    case ($urandom_range(0, 6))
      0:       return 8'h00;
      1:       return 8'hFF;
      2:       return 8'(1 << $urandom_range(0, 7));
      default: return 8'($urandom);
    endcase
  endfunction

  function automatic logic [INV_W-1:0] pick_inv();
    case ($urandom_range(0, 5))
      0:       return 6'h20;
      1:       return 6'h1F;
      2, 3:    return 6'(int'($urandom_range(0, 32)) - 16);
      default: return 6'($urandom);
    endcase
  endfunction

  function automatic logic [SPREAD_W-1:0] pick_spread();
    case ($urandom_range(0, 13))
      0:       return 8'd0;
      1:       return 8'd1;
      2:       return 8'd64;
      3:       return 8'd65;
      4:       return 8'd128;
      5:       return 8'd129;
      6:       return 8'd160;
      7:       return 8'd161;
      8:       return 8'd192;
      9:       return 8'd193;
      10:      return 8'd255;
      default: return 8'($urandom);
    endcase
  endfunction

  initial begin : timeout_p
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin : stim_p
    logic [TABLE_W-1:0] tbl;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // reset chord, including indices past the partial count
    send(4'd0);
    send(4'd1);
    send(4'd2);
    send(4'd7);
    send(4'd8);
    send(4'd15);
    drain();

    // full chord with extremes and ties, inversion -1, widest spread
    set_chord(64'hF90C_0505_FF00_7F80, 8'hFF, 6'h3F, 8'd255);
    for (int i = 0; i < 8; i++) send(IDX_W'(i));
    drain();

    // no active partials; a write to a missing register must change nothing
    set_reg(CFG_ACTIVE_MASK, '0);
    set_reg(CFG_IDX_W'(CFG_FIRST_UNUSED + 5), {64{1'b1}});
    send(4'd3);
    send(4'd6);
    send(4'd9);
    drain();

    // single note chord, most negative inversion
    set_chord(64'hF90C_0505_FF00_7F80, 8'h80, 6'h20, 8'd161);
    send(4'd0);
    send(4'd7);
    drain();

    // queried interval above every active one wraps its rank
    set_chord(64'hF90C_0505_FF00_7F80, 8'h55, 6'h1F, 8'd64);
    send(4'd1);
    send(4'd4);
    send(4'd6);
    drain();

    for (int ph = 0; ph < RAND_PHASES; ph++) begin
      idle_on = (ph == RAND_PHASES - 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      for (int k = 0; k < 8; k++) tbl[8*k +: ENTRY_W] = pick_entry();
      set_chord(tbl, pick_mask(), pick_inv(), pick_spread());
      if ($urandom_range(0, 2) == 0)
        set_reg(CFG_IDX_W'($urandom_range(CFG_FIRST_UNUSED, 15)), {$urandom, $urandom});
      for (int i = 0; i < RAND_ITEMS; i++) begin
        if ($urandom_range(0, 9) == 0) send(IDX_W'($urandom_range(8, 15)));
        else send(IDX_W'($urandom_range(0, 7)));
      end
      drain();
    end

    if (mismatches == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+design
design/civ_pkg.sv
design/civ_order.sv
design/chord_inversion_voicer.sv
dv/testbench.sv
